/* sv/upd_pkg.sv */
package upd_pkg;

    // Character and radix constants of the escape syntax.
    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam int unsigned HEX_RADIX_BITS = 4;

    // Register reset value and default queue depths.
    localparam logic [15:0] CAP_RESET = 16'd256;
    localparam int unsigned CMD_DEPTH_DEFAULT = 2;
    localparam int unsigned RES_DEPTH_DEFAULT = 2;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    // Classified source byte: up to three candidate data bytes and the end flag.
    typedef struct packed {
        logic [7:0] byte2;
        logic [7:0] byte1;
        logic [7:0] byte0;
        logic [1:0] count;
        logic       eos;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } res_t;

    // True for 0-9, A-F and a-f.
    function automatic logic is_hex(input logic [7:0] c);
        logic digit;
        logic upper;
        logic lower;
        digit = (c >= 8'h30) && (c <= 8'h39);
        upper = (c >= 8'h41) && (c <= 8'h46);
        lower = (c >= 8'h61) && (c <= 8'h66);
        return digit || upper || lower;
    endfunction

    // Nibble value of a hex digit; zero for anything else.
    function automatic logic [HEX_RADIX_BITS-1:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            v = c - 8'h30;
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            v = c - 8'h41 + 8'd10;
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            v = c - 8'h61 + 8'd10;
        end
        return v[HEX_RADIX_BITS-1:0];
    endfunction

endpackage

/* sv/url_percent_decoder.sv */
// A byte's command is registered in the command queue, its results in the
// result queue. Throughput: one byte per cycle while the result queue has
// room and each byte releases at most one result; extra results hold the
// back end. The command and result queues absorb short stalls on either side.
// Reset (rst_n low, asynchronous) empties both queues, clears the decode and
// count state, and sets dest_capacity to 256.
module url_percent_decoder #(
    parameter int unsigned CMD_DEPTH = upd_pkg::CMD_DEPTH_DEFAULT,
    parameter int unsigned RES_DEPTH = upd_pkg::RES_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        dest_capacity_we,
    input  logic [15:0] dest_capacity,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        end_of_source,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic [1:0]  kind,
    output logic        last
);

    import upd_pkg::*;

    cmd_t cmd_in;
    cmd_t cmd_out;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    res_t res_in;
    res_t res_out;
    logic res_push;
    logic res_full;

    // Front end: escape detection.
    upd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .end_of_source (end_of_source),
        .cmd_push      (cmd_push),
        .cmd           (cmd_in),
        .cmd_full      (cmd_full)
    );

    // Queue of classified bytes.
    upd_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH ($bits(cmd_t))
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    // Back end: capacity accounting and result generation.
    upd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .dest_capacity_we (dest_capacity_we),
        .dest_capacity    (dest_capacity),
        .cmd              (cmd_out),
        .cmd_empty        (cmd_empty),
        .cmd_pop          (cmd_pop),
        .res_push         (res_push),
        .res              (res_in),
        .res_full         (res_full)
    );

    // Result queue toward the consumer.
    upd_fifo #(
        .DEPTH (RES_DEPTH),
        .WIDTH ($bits(res_t))
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign out_byte = res_out.data;
    assign kind     = res_out.kind;
    assign last     = res_out.last;

endmodule

/* sv/upd_fifo.sv */
module upd_fifo #(
    parameter int unsigned DEPTH = 2,
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/upd_front.sv */
module upd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    in_byte,
    input  logic          end_of_source,
    output logic          cmd_push,
    output upd_pkg::cmd_t cmd,
    input  logic          cmd_full
);

    import upd_pkg::*;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } pend_t;

    pend_t      pend_reg, pend_next;
    logic [7:0] first_hex_reg, first_hex_next;
    logic       accept;
    logic       pct_hold;
    logic       b_hex;
    logic [7:0] decoded;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign cmd_push = accept;

    // A '%' that is not the final byte is held back as a possible escape.
    assign pct_hold = (in_byte == PCT_CHAR) && !end_of_source;
    assign b_hex    = is_hex(in_byte);
    assign decoded  = {hex_val(first_hex_reg), hex_val(in_byte)};

    // Classify the byte into the data bytes it releases.
    always_comb
    begin
        cmd            = '0;
        cmd.eos        = end_of_source;
        pend_next      = PEND_NONE;
        first_hex_next = first_hex_reg;
        unique case (pend_reg)
            PEND_PCT:
            begin
                if (b_hex && !end_of_source)
                begin
                    pend_next      = PEND_DIGIT;
                    first_hex_next = in_byte;
                end
                else
                begin
                    cmd.byte0 = PCT_CHAR;
                    if (pct_hold)
                    begin
                        cmd.count = 2'd1;
                        pend_next = PEND_PCT;
                    end
                    else
                    begin
                        cmd.byte1 = in_byte;
                        cmd.count = 2'd2;
                    end
                end
            end
            PEND_DIGIT:
            begin
                if (b_hex)
                begin
                    cmd.byte0 = decoded;
                    cmd.count = 2'd1;
                end
                else
                begin
                    cmd.byte0 = PCT_CHAR;
                    cmd.byte1 = first_hex_reg;
                    if (pct_hold)
                    begin
                        cmd.count = 2'd2;
                        pend_next = PEND_PCT;
                    end
                    else
                    begin
                        cmd.byte2 = in_byte;
                        cmd.count = 2'd3;
                    end
                end
            end
            default:
            begin
                if (pct_hold)
                begin
                    pend_next = PEND_PCT;
                end
                else
                begin
                    cmd.byte0 = in_byte;
                    cmd.count = 2'd1;
                end
            end
        endcase
        if (end_of_source)
        begin
            first_hex_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= PEND_NONE;
            first_hex_reg <= 8'd0;
        end
        else if (accept)
        begin
            pend_reg      <= pend_next;
            first_hex_reg <= first_hex_next;
        end
    end

endmodule

/* sv/upd_back.sv */
module upd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          dest_capacity_we,
    input  logic [15:0]   dest_capacity,
    input  upd_pkg::cmd_t cmd,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    output logic          res_push,
    output upd_pkg::res_t res,
    input  logic          res_full
);

    import upd_pkg::*;

    logic [15:0] cap_reg;
    logic [15:0] emitted_reg, emitted_next;
    logic        ovf_reg, ovf_next;
    logic [1:0]  idx_reg, idx_next;
    logic        go;
    logic        at_limit;
    logic        final_byte;
    logic [7:0]  cur_byte;

    assign go = !cmd_empty && !res_full;

    // One more byte would leave no room for the terminator.
    assign at_limit   = ({1'b0, emitted_reg} + 17'd1) >= {1'b0, cap_reg};
    assign final_byte = ((idx_reg + 2'd1) == cmd.count);

    // Select the data byte at the current position of the transaction.
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    cur_byte = cmd.byte0;
            2'd1:    cur_byte = cmd.byte1;
            default: cur_byte = cmd.byte2;
        endcase
    end

    // Emit at most one result per cycle from the head command while the result queue has room.
    always_comb
    begin
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res.data     = 8'd0;
        res.kind     = KIND_DATA;
        res.last     = 1'b0;
        emitted_next = emitted_reg;
        ovf_next     = ovf_reg;
        idx_next     = idx_reg;
        if (go)
        begin
            priority if (ovf_reg)
            begin
                // Rest of the string is dropped until its final byte.
                cmd_pop  = 1'b1;
                idx_next = 2'd0;
                if (cmd.eos)
                begin
                    ovf_next     = 1'b0;
                    emitted_next = 16'd0;
                end
            end
            else if (idx_reg < cmd.count)
            begin
                res_push = 1'b1;
                if (at_limit)
                begin
                    res.kind = KIND_OVERFLOW;
                    res.last = 1'b1;
                    cmd_pop  = 1'b1;
                    idx_next = 2'd0;
                    if (cmd.eos)
                    begin
                        emitted_next = 16'd0;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    res.data     = cur_byte;
                    res.last     = final_byte && !cmd.eos;
                    emitted_next = emitted_reg + 16'd1;
                    if (final_byte && !cmd.eos)
                    begin
                        cmd_pop  = 1'b1;
                        idx_next = 2'd0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            else
            begin
                // All data bytes done; pop the command and, on the final byte, report the end of the string.
                cmd_pop  = 1'b1;
                idx_next = 2'd0;
                if (cmd.eos)
                begin
                    res_push     = 1'b1;
                    res.kind     = KIND_DONE;
                    res.last     = 1'b1;
                    emitted_next = 16'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CAP_RESET;
            emitted_reg <= 16'd0;
            ovf_reg     <= 1'b0;
            idx_reg     <= 2'd0;
        end
        else
        begin
            if (dest_capacity_we)
            begin
                cap_reg <= dest_capacity;
            end
            emitted_reg <= emitted_next;
            ovf_reg     <= ovf_next;
            idx_reg     <= idx_next;
        end
    end

endmodule

/* bench/url_percent_decoder_tb.sv */
`timescale 1ns / 100ps

module url_percent_decoder_tb;

    import upd_pkg::*;

    // Codes for what the decoder holds between bytes.
    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    localparam int MAX_PER_BYTE = 4;

    logic        clk;
    logic        rst_n;
    logic        dest_capacity_we;
    logic [15:0] dest_capacity;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        end_of_source;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic        last;

    // Decoder state as tracked by the bench.
    logic [15:0] capacity_now;
    logic [1:0]  held_count;
    logic [7:0]  held_digit;
    logic [15:0] emitted_bytes;
    logic        overflow_seen;

    res_t        byte_results[$];
    res_t        decoded_q[$];
    logic [7:0]  src_bytes[$];
    int          error_count = 0;
    bit          calm_tail = 1'b0;

    url_percent_decoder i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .dest_capacity_we (dest_capacity_we),
        .dest_capacity    (dest_capacity),
        .push             (push),
        .full             (full),
        .in_byte          (in_byte),
        .end_of_source    (end_of_source),
        .empty            (empty),
        .pop              (pop),
        .out_byte         (out_byte),
        .kind             (kind),
        .last             (last)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // 0-9, A-F and a-f are the only hex digits.
    function automatic bit hex_digit(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // Nibble of a byte already known to be a hex digit.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else
        begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

    // Queue one result of the current byte, at most four per byte.
    function automatic void add_result(input logic [7:0] data, input kind_t k);
        res_t r;
        if (byte_results.size() >= MAX_PER_BYTE)
        begin
            return;
        end
        r.data = data;
        r.kind = k;
        r.last = 1'b0;
        byte_results.push_back(r);
    endfunction

    // A data byte either fits in the destination or turns into an overflow status.
    function automatic void emit_decoded(input logic [7:0] data);
        logic [15:0] room;
        room = (capacity_now == 16'd0) ? 16'd0 : capacity_now - 16'd1;
        if (overflow_seen)
        begin
            return;
        end
        if (emitted_bytes >= room)
        begin
            overflow_seen = 1'b1;
            held_count = HELD_NONE;
            add_result(8'h00, KIND_OVERFLOW);
            return;
        end
        add_result(data, KIND_DATA);
        emitted_bytes = emitted_bytes + 16'd1;
    endfunction

    // A byte outside an escape: a percent opens one unless the string ends here.
    function automatic void take_plain(input logic [7:0] b, input bit eos);
        if (overflow_seen)
        begin
            return;
        end
        if ((b == PCT_CHAR) && !eos)
        begin
            held_count = HELD_PCT;
            return;
        end
        emit_decoded(b);
    endfunction

    // Work out every result one accepted source byte causes.
    function automatic void decode_source_byte(input logic [7:0] b, input bit eos);
        res_t r;
        byte_results.delete();
        if (!overflow_seen)
        begin
            case (held_count)
                HELD_PCT:
                begin
                    if (hex_digit(b) && !eos)
                    begin
                        held_count = HELD_DIGIT;
                        held_digit = b;
                    end
                    else
                    begin
                        held_count = HELD_NONE;
                        emit_decoded(PCT_CHAR);
                        take_plain(b, eos);
                    end
                end
                HELD_DIGIT:
                begin
                    held_count = HELD_NONE;
                    if (hex_digit(b))
                    begin
                        emit_decoded({nibble_of(held_digit), nibble_of(b)});
                    end
                    else
                    begin
                        emit_decoded(PCT_CHAR);
                        emit_decoded(held_digit);
                        take_plain(b, eos);
                    end
                end
                default:
                begin
                    held_count = HELD_NONE;
                    take_plain(b, eos);
                end
            endcase
        end

        // The final byte reports success unless the string overflowed, then clears all.
        if (eos)
        begin
            if (!overflow_seen)
            begin
                add_result(8'h00, KIND_DONE);
            end
            held_count = HELD_NONE;
            held_digit = 8'h00;
            emitted_bytes = 16'd0;
            overflow_seen = 1'b0;
        end

        foreach (byte_results[i])
        begin
            r = byte_results[i];
            r.last = (i == byte_results.size() - 1);
            decoded_q.push_back(r);
        end
    endfunction

    // Send one source byte, with an occasional idle burst in front of it.
    task automatic send_byte(input logic [7:0] b, input bit eos);
        int gap;
        if (!calm_tail && ($urandom_range(0, 3) == 0))
        begin
            gap = $urandom_range(1, 15);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        in_byte <= b;
        end_of_source <= eos;
        do @(posedge clk); while (full);
        decode_source_byte(b, eos);
    endtask

    task automatic send_text(input string s, input bit with_eos);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], with_eos && (i == s.len() - 1));
        end
    endtask

    // Send the built source string, flagging its final byte.
    task automatic send_source(output int count);
        count = src_bytes.size();
        foreach (src_bytes[i])
        begin
            send_byte(src_bytes[i], i == src_bytes.size() - 1);
        end
    endtask

    // Change the capacity once nothing is in flight any more.
    task automatic write_capacity(input logic [15:0] value);
        push <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        dest_capacity_we <= 1'b1;
        dest_capacity <= value;
        @(posedge clk);
        dest_capacity_we <= 1'b0;
        capacity_now = value;
    endtask

    function automatic logic [7:0] random_hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
        begin
            return 8'(8'h30 + r);
        end
        else if (r < 16)
        begin
            return 8'(8'h61 + r - 10);
        end
        return 8'(8'h41 + r - 16);
    endfunction

    // Mostly valid escapes, with plain bytes, broken escapes and cut-off endings.
    task automatic build_source(input int pieces);
        int pick;
        src_bytes.delete();
        repeat (pieces)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                src_bytes.push_back(PCT_CHAR);
                src_bytes.push_back(random_hex_char());
                src_bytes.push_back(random_hex_char());
            end
            else if (pick < 8)
            begin
                src_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                src_bytes.push_back(PCT_CHAR);
                if ($urandom_range(0, 1) == 1)
                begin
                    src_bytes.push_back(random_hex_char());
                end
                src_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ((src_bytes.size() > 1) && ($urandom_range(0, 3) == 0))
        begin
            void'(src_bytes.pop_back());
        end
    endtask

    // Valid escapes in both cases, broken escapes and escapes cut off by the end.
    task automatic test_escape_decoding();
        send_text("%41%fa%Fc", 1'b1);
        send_text("%%4G", 1'b1);
        send_text("%4", 1'b1);
        send_text("%", 1'b1);
    endtask

    // Overflow on the first byte, with zero capacity, and during an escape flush.
    task automatic test_capacity_overflow();
        write_capacity(16'd1);
        send_text("ab", 1'b1);
        write_capacity(16'd0);
        send_text("%4", 1'b1);
        write_capacity(16'd2);
        send_text("a%4G", 1'b1);
    endtask

    // A smaller capacity written in the middle of a string applies to its next byte.
    task automatic test_capacity_mid_string();
        write_capacity(16'd4);
        send_text("xy", 1'b0);
        write_capacity(16'd2);
        send_text("z", 1'b1);
    endtask

    // Random strings across several capacity settings; the last phase runs without idling.
    task automatic test_random_strings();
        logic [15:0] phase_caps[6];
        int sent;
        int count;
        phase_caps[0] = 16'($urandom_range(2, 12));
        phase_caps[1] = 16'd0;
        phase_caps[2] = 16'hFFFF;
        phase_caps[3] = 16'($urandom_range(5, 40));
        phase_caps[4] = 16'd1;
        phase_caps[5] = 16'($urandom_range(100, 300));
        for (int p = 0; p < 6; p++)
        begin
            write_capacity(phase_caps[p]);
            if (p == 5)
            begin
                calm_tail = 1'b1;
            end
            sent = 0;
            while (sent < 30)
            begin
                build_source($urandom_range(1, 6));
                send_source(count);
                sent += count;
            end
        end
    endtask

    // Result side: random pop stalls, and each transaction checked against the oldest expectation.
    initial
    begin
        int   stall;
        res_t want;
        stall = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result: out_byte %0h kind %0d last %0d",
                           out_byte, kind, last);
                    error_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %0h, actual %0h", want.data, out_byte);
                        error_count++;
                    end
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, kind);
                        error_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        error_count++;
                    end
                end
            end
            if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if (!calm_tail && ($urandom_range(0, 7) == 0))
            begin
                stall = $urandom_range(0, 14);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Reset, the tests in turn, then drain and report.
    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        in_byte <= 8'h00;
        end_of_source <= 1'b0;
        dest_capacity_we <= 1'b0;
        dest_capacity <= CAP_RESET;
        capacity_now = CAP_RESET;
        held_count = HELD_NONE;
        held_digit = 8'h00;
        emitted_bytes = 16'd0;
        overflow_seen = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_escape_decoding();
        test_capacity_overflow();
        test_capacity_mid_string();
        test_random_strings();

        push <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
